@@ rtl/mwsp_pkg.sv @@
// Shared types and constants for the Modbus wind sensor poller.
// No dependencies.
package mwsp_pkg;

   localparam int TICK_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH       = 4;

   localparam logic [7:0]  INTERVAL_RESET = 8'd10;
   localparam logic [7:0]  EN_WAIT_RESET  = 8'd2;
   localparam logic [11:0] TIMEOUT_RESET  = 12'd200;

   typedef struct packed {
      logic [7:0]  interval_units;
      logic [7:0]  enable_wait;
      logic [11:0] reply_timeout;
   } cfg_type;

   // one queued result descriptor; a poll request expands into eight beats
   typedef struct packed {
      logic        is_request;
      logic        drive_enable;
      logic [2:0]  event_code;
      logic        wind_valid;
      logic [15:0] wind_tenths;
   } result_type;

endpackage

@@ rtl/mwsp_csr.sv @@
// Configuration registers behind the APB-style port.
// Depends on mwsp_pkg.
module mwsp_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output mwsp_pkg::cfg_type cfg
);

   localparam logic [1:0] REG_INTERVAL = 2'd0;
   localparam logic [1:0] REG_EN_WAIT  = 2'd1;
   localparam logic [1:0] REG_TIMEOUT  = 2'd2;

   logic [7:0]  interval_ff;
   logic [7:0]  en_wait_ff;
   logic [11:0] timeout_ff;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= mwsp_pkg::INTERVAL_RESET;
         en_wait_ff  <= mwsp_pkg::EN_WAIT_RESET;
         timeout_ff  <= mwsp_pkg::TIMEOUT_RESET;
      end else if (wr_en) begin
         unique case (csr_paddr[3:2])
            REG_INTERVAL: interval_ff <= csr_pwdata[7:0];
            REG_EN_WAIT:  en_wait_ff  <= csr_pwdata[7:0];
            REG_TIMEOUT:  timeout_ff  <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_INTERVAL: csr_prdata = {24'd0, interval_ff};
         REG_EN_WAIT:  csr_prdata = {24'd0, en_wait_ff};
         REG_TIMEOUT:  csr_prdata = {20'd0, timeout_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   assign cfg.interval_units = interval_ff;
   assign cfg.enable_wait    = en_wait_ff;
   assign cfg.reply_timeout  = timeout_ff;

endmodule

@@ rtl/mwsp_front.sv @@
// Front end: poll sequencer, reply capture, running CRC and reply check.
// Emits one result descriptor per accepted request. Depends on mwsp_pkg.
module mwsp_front #(
   parameter int TICK_COUNTER_BITS = mwsp_pkg::TICK_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mwsp_pkg::cfg_type    cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic                 command,
   input  logic [7:0]           rx_data,
   input  logic                 tx_busy,
   output logic                 push_valid,
   output mwsp_pkg::result_type push_data,
   input  logic                 push_ready
);

   localparam int CmpW = (TICK_COUNTER_BITS > 15) ? TICK_COUNTER_BITS : 15;

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_WAIT_HIGH = 3'd1;
   localparam logic [2:0] PH_REQUEST   = 3'd2;
   localparam logic [2:0] PH_WAIT_LOW  = 3'd3;
   localparam logic [2:0] PH_READ      = 3'd4;

   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_MALFORMED = 3'd1;
   localparam logic [2:0] EV_CRC       = 3'd2;
   localparam logic [2:0] EV_TIMEOUT   = 3'd3;
   localparam logic [2:0] EV_READING   = 3'd4;

   logic [2:0]                   phase_ff, phase_in;
   logic [TICK_COUNTER_BITS-1:0] elapsed_ff, elapsed_in, elapsed_inc;
   logic [3:0]                   rx_count_ff, rx_count_in;
   logic [7:0]                   reply_ff [7];
   logic [15:0]                  crc_ff, crc_in;
   logic [15:0]                  wind_value_ff, wind_value_in;
   logic                         wind_ok_ff, wind_ok_in;
   logic [2:0]                   event_code;
   logic                         is_request;
   logic                         fire;
   logic                         store_byte;
   logic [14:0]                  interval;
   logic                         sat;
   logic                         reach_interval, reach_wait, reach_timeout;
   logic                         hdr_ok, crc_ok;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

   assign fire     = in_valid & push_ready;
   assign in_ready = push_ready;

   assign interval    = 15'(cfg.interval_units) * 15'd100;
   assign sat         = &elapsed_ff;
   assign elapsed_inc = sat ? elapsed_ff : elapsed_ff + 1'b1;

   assign reach_interval = (CmpW'(elapsed_inc) >= CmpW'(interval)) || (&elapsed_inc);
   assign reach_wait     = (CmpW'(elapsed_inc) >= CmpW'(cfg.enable_wait)) || (&elapsed_inc);
   assign reach_timeout  = (CmpW'(elapsed_inc) >= CmpW'(cfg.reply_timeout)) || (&elapsed_inc);

   assign hdr_ok = (reply_ff[0] == 8'h01) && (reply_ff[1] == 8'h03) && (reply_ff[2] == 8'h02);
   assign crc_ok = (reply_ff[5] == crc_ff[7:0]) && (reply_ff[6] == crc_ff[15:8]);

   assign store_byte = fire & command & (phase_ff == PH_READ) & (rx_count_ff < 4'd7);

   always_comb begin
      phase_in      = phase_ff;
      elapsed_in    = elapsed_ff;
      rx_count_in   = rx_count_ff;
      crc_in        = crc_ff;
      wind_value_in = wind_value_ff;
      wind_ok_in    = wind_ok_ff;
      event_code    = EV_NONE;
      is_request    = 1'b0;
      if (command) begin
         if (phase_ff == PH_READ) begin
            if (rx_count_ff < 4'd5) begin
               crc_in = crc_byte(crc_ff, rx_data);
            end
            if (rx_count_ff < 4'd8) begin
               rx_count_in = rx_count_ff + 4'd1;
            end
         end
      end else begin
         elapsed_in = elapsed_inc;
         if (interval != 15'd0) begin
            unique case (phase_ff)
               PH_IDLE: begin
                  if (reach_interval) begin
                     elapsed_in = '0;
                     phase_in   = PH_WAIT_HIGH;
                  end
               end
               PH_WAIT_HIGH: begin
                  if (reach_wait) begin
                     elapsed_in = '0;
                     phase_in   = PH_REQUEST;
                  end
               end
               PH_REQUEST: begin
                  is_request = 1'b1;
                  phase_in   = PH_WAIT_LOW;
               end
               PH_WAIT_LOW: begin
                  if (tx_busy) begin
                     elapsed_in = '0;
                  end else if (reach_wait) begin
                     elapsed_in  = '0;
                     rx_count_in = 4'd0;
                     crc_in      = 16'hFFFF;
                     phase_in    = PH_READ;
                  end
               end
               default: begin
                  if (rx_count_ff >= 4'd7) begin
                     wind_ok_in  = 1'b0;
                     phase_in    = PH_IDLE;
                     rx_count_in = 4'd0;
                     if (rx_count_ff > 4'd7) begin
                        elapsed_in = '0;
                        event_code = EV_MALFORMED;
                     end else if (!hdr_ok) begin
                        event_code = EV_MALFORMED;
                     end else if (!crc_ok) begin
                        event_code = EV_CRC;
                     end else begin
                        wind_value_in = {reply_ff[3], reply_ff[4]};
                        wind_ok_in    = 1'b1;
                        elapsed_in    = '0;
                        event_code    = EV_READING;
                     end
                  end else if (reach_timeout) begin
                     event_code  = EV_TIMEOUT;
                     wind_ok_in  = 1'b0;
                     rx_count_in = 4'd0;
                     phase_in    = PH_IDLE;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         elapsed_ff    <= '0;
         rx_count_ff   <= 4'd0;
         wind_value_ff <= 16'd0;
         wind_ok_ff    <= 1'b0;
         crc_ff        <= 16'hFFFF;
      end else if (fire) begin
         phase_ff      <= phase_in;
         elapsed_ff    <= elapsed_in;
         rx_count_ff   <= rx_count_in;
         wind_value_ff <= wind_value_in;
         wind_ok_ff    <= wind_ok_in;
         crc_ff        <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_byte) begin
         reply_ff[rx_count_ff[2:0]] <= rx_data;
      end
   end

   assign push_valid             = in_valid;
   assign push_data.is_request   = is_request;
   assign push_data.drive_enable = (phase_in == PH_WAIT_HIGH) || (phase_in == PH_REQUEST)
                                   || (phase_in == PH_WAIT_LOW) || is_request;
   assign push_data.event_code   = event_code;
   assign push_data.wind_valid   = wind_ok_in;
   assign push_data.wind_tenths  = wind_value_in;

endmodule

@@ rtl/mwsp_queue.sv @@
// Short descriptor queue between the front end and the result stage.
// Depends on mwsp_pkg.
module mwsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  mwsp_pkg::result_type push_data,
   output logic                 push_ready,
   output logic                 pop_valid,
   output mwsp_pkg::result_type pop_data,
   input  logic                 pop
);

   localparam int PtrW = $clog2(mwsp_pkg::QUEUE_DEPTH);

   mwsp_pkg::result_type entry_ff [mwsp_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]   count_ff;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != (PtrW+1)'(mwsp_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop & pop_valid;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/mwsp_back.sv @@
// Result stage: output register, expands a poll descriptor into the 8 frame bytes.
// Depends on mwsp_pkg.
module mwsp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   input  mwsp_pkg::result_type pop_data,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,
   output logic                 rsp_tlast
);

   // read request 01 03 00 00 00 01 84 0A, first byte in the low bits
   localparam logic [63:0] RequestFrame = 64'h0A84_0100_0000_0301;

   mwsp_pkg::result_type cur_ff;
   logic       valid_ff;
   logic [2:0] beat_ff;
   logic       last_beat;
   logic       fire;
   logic [7:0] tx_byte;

   assign last_beat = !cur_ff.is_request || (beat_ff == 3'd7);
   assign fire      = valid_ff & rsp_tready;
   assign pop       = pop_valid & (!valid_ff || (fire && last_beat));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= 3'd0;
      end else if (fire && !last_beat) begin
         beat_ff <= beat_ff + 3'd1;
      end else if (!valid_ff || fire) begin
         valid_ff <= pop_valid;
         beat_ff  <= 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= pop_data;
      end
   end

   assign tx_byte    = cur_ff.is_request ? RequestFrame[{beat_ff, 3'b000} +: 8] : 8'd0;
   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_beat;
   assign rsp_tdata  = {2'b00, cur_ff.wind_tenths, cur_ff.wind_valid, cur_ff.event_code,
                        cur_ff.drive_enable, tx_byte, cur_ff.is_request};

endmodule

@@ rtl/modbus_wind_sensor_poller.sv @@
// Modbus RTU wind sensor poller, top level.
// Depends on mwsp_pkg, mwsp_csr, mwsp_front, mwsp_queue, mwsp_back.
//
// Usage: the req channel carries 1 ms ticks (req_tuser = 0, tx_busy sampled)
// and received serial bytes (req_tuser = 1). Each request gives one result,
// except the tick that sends the poll, which gives the eight bytes of the read
// frame with tx_valid set; rsp_tlast marks the final result of each request.
// The front end updates the poll sequencer in the cycle a request is taken;
// the reply CRC is accumulated over the first five reply bytes. Results reach
// rsp through the descriptor queue and the output register. One request per
// cycle is accepted while the 4-entry descriptor queue has room; the result
// stage drains one result per cycle while rsp_tready is high, and a poll tick
// gives eight. When the receiver stalls, the queue fills and req_tready drops.
// Reset puts the sequencer in idle, clears the counters and the reading, and
// loads the register defaults (interval 10, enable wait 2, timeout 200).
// Registers live at byte addresses 0, 4 and 8; the user is to issue writes only while idle, not enforced by the block.
module modbus_wind_sensor_poller #(
   parameter int TICK_COUNTER_BITS = mwsp_pkg::TICK_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // rx_data[7:0], tx_busy[8], zero fill
   input  logic        req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // tx_valid, tx_data[8:1], drive_enable, event_res[12:10],
                                   // wind_valid, wind_tenths[29:14], zero fill
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   mwsp_pkg::cfg_type    cfg;
   mwsp_pkg::result_type push_data, pop_data;
   logic                 push_valid, push_ready, pop_valid, pop;

   mwsp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mwsp_front #(
      .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .command    (req_tuser),
      .rx_data    (req_tdata[7:0]),
      .tx_busy    (req_tdata[8]),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   mwsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop)
   );

   mwsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ tb/sv/wind_poll_tb_pkg.sv @@
// Shared codes and the result scoreboard for the wind sensor poller testbench.
// No dependencies; used by tb_modbus_wind_sensor_poller.
package wind_poll_tb_pkg;

   localparam bit CMD_TICK = 1'b0;
   localparam bit CMD_BYTE = 1'b1;

   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_MALFORMED = 3'd1;
   localparam logic [2:0] EV_CRC       = 3'd2;
   localparam logic [2:0] EV_TIMEOUT   = 3'd3;
   localparam logic [2:0] EV_READING   = 3'd4;

   localparam logic [3:0] CSR_INTERVAL = 4'd0;
   localparam logic [3:0] CSR_EN_WAIT  = 4'd4;
   localparam logic [3:0] CSR_TIMEOUT  = 4'd8;

   localparam logic [15:0] TICKS_SATURATED = 16'hFFFF;
   localparam logic [7:0]  FRAME_ADDR      = 8'h01;
   localparam logic [7:0]  FRAME_FUNC      = 8'h03;
   localparam logic [7:0]  FRAME_COUNT     = 8'h02;
   // read request 01 03 00 00 00 01 84 0A, first byte in the low bits
   localparam logic [63:0] REQUEST_FRAME   = 64'h0A84_0100_0000_0301;

   typedef enum logic [2:0] {
      POLL_IDLE, POLL_WAIT_HIGH, POLL_REQUEST, POLL_WAIT_LOW, POLL_READ
   } poll_phase_e;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_data;
      logic        drive_en;
      logic [2:0]  ev;
      logic        wind_ok;
      logic [15:0] wind;
      logic        last;
   } sensor_beat_t;

   class wind_poll_scoreboard;
      logic [7:0]  interval_units = 8'd10;
      logic [7:0]  enable_wait    = 8'd2;
      logic [11:0] reply_timeout  = 12'd200;

      poll_phase_e phase      = POLL_IDLE;
      logic [15:0] elapsed    = '0;
      logic [3:0]  rx_count   = '0;
      logic [7:0]  reply [7];
      logic [15:0] wind_value = '0;
      bit          wind_ok    = 1'b0;

      sensor_beat_t pending [$];
      int errors  = 0;
      int results = 0;

      function logic [15:0] crc16(logic [7:0] frame [7], int n);
         logic [15:0] crc;
         crc = 16'hFFFF;
         for (int i = 0; i < n; i++) begin
            crc ^= {8'h00, frame[i]};
            for (int b = 0; b < 8; b++)
               crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
         end
         return crc;
      endfunction

      function bit reached(int limit);
         return int'(elapsed) >= limit || elapsed == TICKS_SATURATED;
      endfunction

      function void push(bit txv, logic [7:0] txd, logic [2:0] ev, bit lst);
         sensor_beat_t beat;
         beat.tx_valid = txv;
         beat.tx_data  = txd;
         beat.drive_en = (phase == POLL_WAIT_HIGH || phase == POLL_REQUEST ||
                          phase == POLL_WAIT_LOW);
         beat.ev       = ev;
         beat.wind_ok  = wind_ok;
         beat.wind     = wind_value;
         beat.last     = lst;
         pending.push_back(beat);
      endfunction

      function void set_reg(logic [3:0] addr, logic [31:0] value);
         case (addr)
            CSR_INTERVAL: interval_units = value[7:0];
            CSR_EN_WAIT:  enable_wait    = value[7:0];
            CSR_TIMEOUT:  reply_timeout  = value[11:0];
            default: ;
         endcase
      endfunction

      function logic [2:0] judge_reply();
         logic [15:0] crc;
         wind_ok = 1'b0;
         phase   = POLL_IDLE;
         if (rx_count > 4'd7) begin
            elapsed = '0;
            return EV_MALFORMED;
         end
         if (reply[0] != FRAME_ADDR || reply[1] != FRAME_FUNC || reply[2] != FRAME_COUNT)
            return EV_MALFORMED;
         crc = crc16(reply, 5);
         if (reply[5] != crc[7:0] || reply[6] != crc[15:8])
            return EV_CRC;
         wind_value = {reply[3], reply[4]};
         wind_ok    = 1'b1;
         elapsed    = '0;
         return EV_READING;
      endfunction

      function void note_request(bit cmd, logic [7:0] rx, bit busy);
         logic [2:0] ev;
         int interval;
         ev = EV_NONE;
         if (cmd == CMD_BYTE) begin
            if (phase == POLL_READ) begin
               if (rx_count < 4'd7) reply[rx_count] = rx;
               if (rx_count < 4'd8) rx_count++;
            end
            push(1'b0, 8'h00, EV_NONE, 1'b1);
            return;
         end
         if (elapsed != TICKS_SATURATED) elapsed++;
         interval = int'(interval_units) * 100;
         if (interval == 0) begin
            push(1'b0, 8'h00, EV_NONE, 1'b1);
            return;
         end
         case (phase)
            POLL_IDLE: begin
               if (reached(interval)) begin
                  elapsed = '0;
                  phase   = POLL_WAIT_HIGH;
               end
            end
            POLL_WAIT_HIGH: begin
               if (reached(int'(enable_wait))) begin
                  elapsed = '0;
                  phase   = POLL_REQUEST;
               end
            end
            POLL_REQUEST: begin
               for (int k = 0; k < 8; k++)
                  push(1'b1, REQUEST_FRAME[8*k +: 8], EV_NONE, k == 7);
               phase = POLL_WAIT_LOW;
               return;
            end
            POLL_WAIT_LOW: begin
               if (busy) begin
                  elapsed = '0;
               end else if (reached(int'(enable_wait))) begin
                  elapsed  = '0;
                  rx_count = '0;
                  phase    = POLL_READ;
               end
            end
            default: begin
               if (rx_count >= 4'd7) begin
                  ev       = judge_reply();
                  rx_count = '0;
               end else if (reached(int'(reply_timeout))) begin
                  ev       = EV_TIMEOUT;
                  wind_ok  = 1'b0;
                  rx_count = '0;
                  phase    = POLL_IDLE;
               end
            end
         endcase
         push(1'b0, 8'h00, ev, 1'b1);
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report($sformatf("result %0d %s: got %h, expected %h", results, name, got, want));
      endtask

      task check_result(logic [31:0] data, logic lst);
         sensor_beat_t want;
         results++;
         if (pending.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected", results));
            return;
         end
         want = pending.pop_front();
         compare_field("tx_valid",     16'(data[0]),     16'(want.tx_valid));
         compare_field("tx_data",      16'(data[8:1]),   16'(want.tx_data));
         compare_field("drive_enable", 16'(data[9]),     16'(want.drive_en));
         compare_field("event_res",    16'(data[12:10]), 16'(want.ev));
         compare_field("wind_valid",   16'(data[13]),    16'(want.wind_ok));
         compare_field("wind_tenths",  data[29:14],      want.wind);
         compare_field("last",         16'(lst),         16'(want.last));
      endtask
   endclass

endpackage

@@ tb/sv/tb_modbus_wind_sensor_poller.sv @@
// Testbench top for the Modbus wind sensor poller: steers a full poll cycle
// through the request stream and checks every result. Depends on wind_poll_tb_pkg.
module tb_modbus_wind_sensor_poller;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 20_000;

   typedef enum {
      REPLY_GOOD, REPLY_BAD_HEADER, REPLY_BAD_CRC, REPLY_NOISE, REPLY_OVERLONG, REPLY_SILENT
   } reply_kind_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic [15:0] req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tready  = 1'b0;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [31:0] rsp_tdata;
   wire         rsp_tlast;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   bit calm   = 1'b0;
   int cycles = 0;
   wind_poll_tb_pkg::wind_poll_scoreboard sb = new;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   modbus_wind_sensor_poller uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // rx_data[7:0], tx_busy[8]
      .req_tuser   (req_tuser),   // command
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // tx_valid, tx_data, drive_enable, event_res, wind_valid,
                                  // wind_tenths
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("modbus_wind_sensor_poller verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tlast);
      rsp_tready <= calm || ($urandom_range(99) >= 6);
   end

   task automatic send_req(bit cmd, logic [7:0] rx, bit busy);
      while (!calm && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, busy, rx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(cmd, rx, busy);
   endtask

   task automatic send_random();
      send_req(1'($urandom) ? wind_poll_tb_pkg::CMD_BYTE : wind_poll_tb_pkg::CMD_TICK,
               8'($urandom), 1'($urandom));
   endtask

   task automatic req_hold();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending and let every expected result drain
   task automatic settle();
      req_hold();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [3:0] addr, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_reg(addr, value);
      @(posedge clock);
   endtask

   task automatic configure(logic [7:0] interval, logic [7:0] en_wait, logic [11:0] timeout);
      settle();
      csr_write(wind_poll_tb_pkg::CSR_INTERVAL, {24'd0, interval});
      csr_write(wind_poll_tb_pkg::CSR_EN_WAIT,  {24'd0, en_wait});
      csr_write(wind_poll_tb_pkg::CSR_TIMEOUT,  {20'd0, timeout});
   endtask

   // run the sequencer up to the read phase, then feed one reply of the given kind
   task automatic poll_round(reply_kind_type kind, logic [15:0] speed);
      logic [7:0]  body [7];
      logic [15:0] crc;
      int nbytes;
      int busy_budget;
      busy_budget = $urandom_range(4);
      while (sb.phase != wind_poll_tb_pkg::POLL_READ) begin
         if ($urandom_range(99) < 5)
            send_req(wind_poll_tb_pkg::CMD_BYTE, 8'($urandom), 1'($urandom));
         if (sb.phase == wind_poll_tb_pkg::POLL_WAIT_LOW && busy_budget > 0 &&
             $urandom_range(99) < 30) begin
            busy_budget--;
            send_req(wind_poll_tb_pkg::CMD_TICK, 8'($urandom), 1'b1);
         end else begin
            send_req(wind_poll_tb_pkg::CMD_TICK, 8'($urandom),
                     sb.phase == wind_poll_tb_pkg::POLL_WAIT_LOW ? 1'b0 : 1'($urandom));
         end
      end
      body[0] = wind_poll_tb_pkg::FRAME_ADDR;
      body[1] = wind_poll_tb_pkg::FRAME_FUNC;
      body[2] = wind_poll_tb_pkg::FRAME_COUNT;
      body[3] = speed[15:8];
      body[4] = speed[7:0];
      if (kind == REPLY_BAD_HEADER)
         body[$urandom_range(2)] ^= 8'($urandom_range(1, 255));
      crc = sb.crc16(body, 5);
      body[5] = crc[7:0];
      body[6] = crc[15:8];
      if (kind == REPLY_BAD_CRC)
         body[5 + $urandom_range(1)] ^= 8'($urandom_range(1, 255));
      if (kind == REPLY_NOISE)
         foreach (body[i]) body[i] = 8'($urandom);
      nbytes = 7;
      if (kind == REPLY_OVERLONG) nbytes = 8 + $urandom_range(2);
      if (kind == REPLY_SILENT)   nbytes = $urandom_range(6);
      for (int i = 0; i < nbytes; i++) begin
         if ($urandom_range(99) < 10)
            send_req(wind_poll_tb_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
         send_req(wind_poll_tb_pkg::CMD_BYTE, i < 7 ? body[i] : 8'($urandom), 1'($urandom));
      end
      while (sb.phase == wind_poll_tb_pkg::POLL_READ)
         send_req(wind_poll_tb_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
   endtask

   initial begin
      int pick;
      reply_kind_type kind;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // disabled: bytes dropped, ticks only count
      configure(8'd0, 8'($urandom_range(3)), 12'($urandom_range(4, 12)));
      send_req(wind_poll_tb_pkg::CMD_BYTE, 8'h00, 1'b0);
      send_req(wind_poll_tb_pkg::CMD_BYTE, 8'hFF, 1'b1);
      send_req(wind_poll_tb_pkg::CMD_TICK, 8'hFF, 1'b1);
      send_req(wind_poll_tb_pkg::CMD_TICK, 8'h00, 1'b0);
      repeat (12) send_random();

      configure(8'd1, 8'($urandom_range(3)), 12'($urandom_range(4, 12)));
      // no idling on either side for a stretch of ticks
      calm = 1'b1;
      repeat (40) send_req(wind_poll_tb_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
      calm = 1'b0;
      pick = $urandom_range(99);
      if (pick < 50)      kind = REPLY_GOOD;
      else if (pick < 60) kind = REPLY_BAD_HEADER;
      else if (pick < 70) kind = REPLY_BAD_CRC;
      else if (pick < 80) kind = REPLY_NOISE;
      else if (pick < 90) kind = REPLY_OVERLONG;
      else                kind = REPLY_SILENT;
      poll_round(kind, 16'($urandom));

      // disabled again after a poll
      configure(8'd0, 8'($urandom_range(3)), 12'($urandom_range(4, 12)));
      repeat (16) send_random();

      settle();
      if (sb.errors == 0)
         $display("modbus_wind_sensor_poller verification clean");
      else
         $display("modbus_wind_sensor_poller verification failed");
      $finish;
   end

endmodule

@@ modbus_wind_sensor_poller.f @@
rtl/mwsp_pkg.sv
rtl/mwsp_csr.sv
rtl/mwsp_front.sv
rtl/mwsp_queue.sv
rtl/mwsp_back.sv
rtl/modbus_wind_sensor_poller.sv
tb/sv/wind_poll_tb_pkg.sv
tb/sv/tb_modbus_wind_sensor_poller.sv
